[src/bftr_pkg.sv]
// shared types and constants for the bitmap font text renderer
// no dependencies; imported by bftr_ctrl, bftr_datapath and the top level
package bftr_pkg;

    // parameter defaults
    localparam int MAX_GLYPHS_DEF      = 256;
    localparam int MAX_GLYPH_ROWS_DEF  = 32;
    localparam int MAX_GLYPH_WIDTH_DEF = 32;
    localparam int COORD_BITS_DEF      = 12;

    // fixed field and bus widths
    localparam int SPAN_W     = 14;
    localparam int PIX_W      = 32;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_ORIGIN  = 2'd0,
        KIND_DRAW    = 2'd1,
        KIND_METRICS = 2'd2,
        KIND_ROW     = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_COUNT   = 2'd0,
        CFG_FONT_HEIGHT   = 2'd1,
        CFG_FONT_OFFSET_X = 2'd2,
        CFG_FONT_OFFSET_Y = 2'd3
    } cfg_reg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_PEN
    } state_t;

    // input tdata layout, last declared field in the lowest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic [31:0]        row_bits;
        logic [4:0]         row_index;
        logic [6:0]         advance;
        logic signed [5:0]  glyph_offset_y;
        logic signed [5:0]  glyph_offset_x;
        logic [5:0]         glyph_height;
        logic [5:0]         glyph_width;
        logic [7:0]         glyph_slot;
        logic signed [11:0] origin_y;
        logic signed [11:0] origin_x;
        logic [7:0]         char_code;
    } s_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic start;
        logic search;
        logic capture;
        logic row_rd;
        logic row_ld;
        logic pen_upd;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic match;
        logic match_empty;
        logic exhausted;
        logic out_free;
        logic row_last;
    } dp_status_t;

endpackage

[src/bftr_ctrl.sv]
// controller state machine for the bitmap font text renderer
// depends on bftr_pkg; drives bftr_datapath through command and status structs
module bftr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic [1:0]             s_tuser,
    output logic                   s_tready,
    input  bftr_pkg::dp_status_t   status,
    output bftr_pkg::ctrl_cmd_t    cmd
);
    import bftr_pkg::*;

    state_t state_reg;
    state_t state_next;
    kind_t  kind;

    assign kind = kind_t'(s_tuser);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && kind == KIND_DRAW) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                priority if (status.match) begin
                    state_next = status.match_empty ? ST_PEN : ST_ROW_RD;
                end else if (status.exhausted) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_RD: begin
                state_next = ST_ROW_LD;
            end
            ST_ROW_LD: begin
                if (status.out_free) begin
                    state_next = status.row_last ? ST_PEN : ST_ROW_RD;
                end
            end
            ST_PEN: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                cmd.start  = s_tvalid && kind == KIND_DRAW;
            end
            ST_SEARCH: begin
                cmd.search  = 1'b1;
                cmd.capture = status.match;
            end
            ST_ROW_RD: begin
                cmd.row_rd = 1'b1;
            end
            ST_ROW_LD: begin
                cmd.row_ld = status.out_free;
            end
            ST_PEN: begin
                cmd.pen_upd = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/bftr_datapath.sv]
// datapath: configuration registers, glyph tables, code search and span output register
// depends on bftr_pkg; sequenced by bftr_ctrl
module bftr_datapath #(
    parameter int MAX_GLYPHS      = bftr_pkg::MAX_GLYPHS_DEF,
    parameter int MAX_GLYPH_ROWS  = bftr_pkg::MAX_GLYPH_ROWS_DEF,
    parameter int MAX_GLYPH_WIDTH = bftr_pkg::MAX_GLYPH_WIDTH_DEF,
    parameter int COORD_BITS      = bftr_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [bftr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bftr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [bftr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  bftr_pkg::ctrl_cmd_t             cmd,
    output bftr_pkg::dp_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bftr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import bftr_pkg::*;

    localparam int SLOT_AW   = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int ROW_AW    = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
    localparam int ROW_DEPTH = MAX_GLYPHS * (2 ** ROW_AW);
    localparam int W_CAP     = (MAX_GLYPH_WIDTH < 32) ? MAX_GLYPH_WIDTH : 32;
    localparam int H_CAP     = (MAX_GLYPH_ROWS < 32) ? MAX_GLYPH_ROWS : 32;
    localparam int SUM_W     = ((COORD_BITS > 12) ? COORD_BITS : 12) + 3;
    localparam int BY_W      = 16;
    localparam logic [8:0] SLOT_LIMIT = 9'(MAX_GLYPHS);
    localparam logic [6:0] ROW_LIMIT  = 7'(MAX_GLYPH_ROWS);

    typedef struct packed {
        logic [7:0]        code;
        logic [5:0]        width;
        logic [5:0]        height;
        logic signed [5:0] off_x;
        logic signed [5:0] off_y;
        logic [6:0]        adv;
    } glyph_meta_t;

    s_item_t item;
    kind_t   kind;

    assign item = s_item_t'(s_tdata);
    assign kind = kind_t'(s_tuser);

    // configuration registers
    logic [8:0]        glyph_count_reg;
    logic [5:0]        font_height_reg;
    logic signed [5:0] font_offset_x_reg;
    logic signed [5:0] font_offset_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_count_reg   <= '0;
            font_height_reg   <= '0;
            font_offset_x_reg <= '0;
            font_offset_y_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_GLYPH_COUNT:   glyph_count_reg   <= cfg_data[8:0];
                CFG_FONT_HEIGHT:   font_height_reg   <= cfg_data[5:0];
                CFG_FONT_OFFSET_X: font_offset_x_reg <= cfg_data[5:0];
                CFG_FONT_OFFSET_Y: font_offset_y_reg <= cfg_data[5:0];
                default:           glyph_count_reg   <= glyph_count_reg;
            endcase
        end
    end

    // text origin and pen
    logic signed [11:0]      text_origin_x_reg;
    logic signed [11:0]      text_origin_y_reg;
    logic [COORD_BITS-1:0]   pen_x_reg;
    logic [COORD_BITS-1:0]   pen_x_next;
    logic [COORD_BITS:0]     pen_sum;
    logic [6:0]              adv_reg;

    assign pen_sum    = {1'b0, pen_x_reg} + (COORD_BITS + 1)'(adv_reg);
    assign pen_x_next = pen_sum[COORD_BITS] ? '1 : pen_sum[COORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_origin_x_reg <= '0;
            text_origin_y_reg <= '0;
            pen_x_reg         <= '0;
        end else if (cmd.accept && kind == KIND_ORIGIN) begin
            text_origin_x_reg <= item.origin_x;
            text_origin_y_reg <= item.origin_y;
            pen_x_reg         <= '0;
        end else if (cmd.pen_upd) begin
            pen_x_reg <= pen_x_next;
        end
    end

    // table write decode, out-of-range slots and rows are dropped
    logic                          slot_ok;
    logic                          meta_we;
    logic                          row_we;
    logic [SLOT_AW-1:0]            wr_slot;
    logic [5:0]                    row_idx_ext;
    logic [SLOT_AW+ROW_AW-1:0]     row_waddr;
    glyph_meta_t                   meta_wdata;

    assign slot_ok     = 9'(item.glyph_slot) < SLOT_LIMIT;
    assign meta_we     = cmd.accept && kind == KIND_METRICS && slot_ok;
    assign row_we      = cmd.accept && kind == KIND_ROW && slot_ok
                         && 7'(item.row_index) < ROW_LIMIT;
    assign wr_slot     = item.glyph_slot[SLOT_AW-1:0];
    assign row_idx_ext = 6'(item.row_index);
    assign row_waddr   = {wr_slot, row_idx_ext[ROW_AW-1:0]};

    // width and height clamp on load
    always_comb begin
        meta_wdata.code   = item.char_code;
        meta_wdata.width  = (item.glyph_width > 6'(W_CAP)) ? 6'(W_CAP) : item.glyph_width;
        meta_wdata.height = (item.glyph_height > 6'(H_CAP)) ? 6'(H_CAP) : item.glyph_height;
        meta_wdata.off_x  = item.glyph_offset_x;
        meta_wdata.off_y  = item.glyph_offset_y;
        meta_wdata.adv    = item.advance;
    end

    // search counters
    logic [8:0]         issue_cnt_reg;
    logic               cmp_valid_reg;
    logic [SLOT_AW-1:0] cmp_slot_reg;
    logic [7:0]         code_reg;
    logic [8:0]         limit;
    logic               issue;
    glyph_meta_t        meta_rd_reg;

    assign limit = (glyph_count_reg > SLOT_LIMIT) ? SLOT_LIMIT : glyph_count_reg;
    assign issue = cmd.search && issue_cnt_reg < limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end else if (cmd.start) begin
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end else if (cmd.search) begin
            cmp_valid_reg <= issue;
            if (issue) begin
                issue_cnt_reg <= issue_cnt_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            code_reg <= item.char_code;
        end
        if (issue) begin
            cmp_slot_reg <= issue_cnt_reg[SLOT_AW-1:0];
        end
    end

    // glyph metrics memory, one slot read per cycle during search
    glyph_meta_t meta_mem [MAX_GLYPHS];

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[wr_slot] <= meta_wdata;
        end
        if (issue) begin
            meta_rd_reg <= meta_mem[issue_cnt_reg[SLOT_AW-1:0]];
        end
    end

    // captured glyph and span base coordinates
    logic [SLOT_AW-1:0]        found_slot_reg;
    logic [5:0]                width_reg;
    logic [5:0]                height_reg;
    logic [PIX_W-1:0]          mask_reg;
    logic [SPAN_W-1:0]         base_x_reg;
    logic [SPAN_W-1:0]         base_y_reg;
    logic [5:0]                row_cnt_reg;
    logic [SUM_W-1:0]          bx_sum;
    logic [BY_W-1:0]           by_sum;
    logic [PIX_W-1:0]          mask_calc;

    assign bx_sum = SUM_W'(text_origin_x_reg) + SUM_W'({1'b0, pen_x_reg})
                  + SUM_W'(font_offset_x_reg) + SUM_W'(meta_rd_reg.off_x);
    assign by_sum = BY_W'(text_origin_y_reg) + BY_W'(font_height_reg)
                  - BY_W'(meta_rd_reg.height) - BY_W'(font_offset_y_reg)
                  - BY_W'(meta_rd_reg.off_y);
    assign mask_calc = (meta_rd_reg.width == 6'd0) ? '0
                     : ({PIX_W{1'b1}} << (6'd32 - meta_rd_reg.width));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            found_slot_reg <= cmp_slot_reg;
            width_reg      <= meta_rd_reg.width;
            height_reg     <= meta_rd_reg.height;
            adv_reg        <= meta_rd_reg.adv;
            mask_reg       <= mask_calc;
            base_x_reg     <= bx_sum[SPAN_W-1:0];
            base_y_reg     <= by_sum[SPAN_W-1:0];
        end
    end

    // row counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
        end else if (cmd.capture) begin
            row_cnt_reg <= '0;
        end else if (cmd.row_ld) begin
            row_cnt_reg <= row_cnt_reg + 6'd1;
        end
    end

    // glyph bitmap memory, indexed by slot and row
    logic [PIX_W-1:0]          row_mem [ROW_DEPTH];
    logic [PIX_W-1:0]          row_rd_reg;
    logic [SLOT_AW+ROW_AW-1:0] row_raddr;

    assign row_raddr = {found_slot_reg, row_cnt_reg[ROW_AW-1:0]};

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= item.row_bits;
        end
        if (cmd.row_rd) begin
            row_rd_reg <= row_mem[row_raddr];
        end
    end

    // span output register
    logic              m_tvalid_reg;
    logic [SPAN_W-1:0] out_x_reg;
    logic [SPAN_W-1:0] out_y_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic [5:0]        out_width_reg;
    logic              out_last_reg;
    logic              row_last;

    assign row_last = (row_cnt_reg + 6'd1) == height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.row_ld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_ld) begin
            out_x_reg     <= base_x_reg;
            out_y_reg     <= base_y_reg + SPAN_W'(row_cnt_reg);
            out_pix_reg   <= row_rd_reg & mask_reg;
            out_width_reg <= width_reg;
            out_last_reg  <= row_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_width_reg, out_pix_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

    // status back to the controller
    assign status.match       = cmp_valid_reg && meta_rd_reg.code == code_reg;
    assign status.match_empty = meta_rd_reg.height == 6'd0;
    assign status.exhausted   = !cmp_valid_reg && !(issue_cnt_reg < limit);
    assign status.out_free    = !m_tvalid_reg || m_tready;
    assign status.row_last    = row_last;

endmodule

[src/bitmap_font_text_renderer.sv]
// bitmap font text renderer: origin, glyph load and draw items in, one row span per glyph row out
// origin, metrics and row items are stored on accept; an accepted draw searches the metrics slots
// in order until the code matches or the searched slots run out, then reads and loads each row
// while the output register is free, then updates the pen; one metrics slot is read per cycle
// synchronous reset clears control, configuration, origin and pen; glyph tables are not cleared
// depends on bftr_pkg, bftr_ctrl and bftr_datapath
module bitmap_font_text_renderer #(
    parameter int MAX_GLYPHS      = bftr_pkg::MAX_GLYPHS_DEF,
    parameter int MAX_GLYPH_ROWS  = bftr_pkg::MAX_GLYPH_ROWS_DEF,
    parameter int MAX_GLYPH_WIDTH = bftr_pkg::MAX_GLYPH_WIDTH_DEF,
    parameter int COORD_BITS      = bftr_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bftr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bftr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code, origin_x, origin_y, glyph_slot, glyph_width, glyph_height,
    // glyph_offset_x, glyph_offset_y, advance, row_index, row_bits, zero pad
    input  logic [bftr_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]                      s_tuser,
    // row spans
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // span_x, span_y, span_pixels, span_width, zero pad
    output logic [bftr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import bftr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    bftr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, arithmetic and output register
    bftr_datapath #(
        .MAX_GLYPHS      (MAX_GLYPHS),
        .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
        .COORD_BITS      (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // a span is only loaded when the output register is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_ld |-> (!m_tvalid || m_tready))
        else $error("span loaded over a pending transaction");

    // no new item is taken while a draw is in progress
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.search || cmd.row_rd || cmd.row_ld || cmd.pen_upd))
        else $error("input ready during a draw");

    // the last row of a glyph is followed by the pen update
    a_last_pen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.row_ld && status.row_last) |=> cmd.pen_upd)
        else $error("pen not advanced after last row");
`endif

endmodule

[verif/tb_bitmap_font_text_renderer.sv]
`timescale 1ns / 100ps
// self-checking testbench for bitmap_font_text_renderer: loads glyphs, draws text and checks
// every row span against a behavioral font model kept inside this file
// depends on bftr_pkg and the renderer rtl
module tb_bitmap_font_text_renderer;
    import bftr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 600;
    localparam int GLYPH_SLOTS   = 256;
    localparam int GLYPH_ROWS    = 32;
    localparam int PEN_MAX       = 4095;
    localparam int FONT_ROW      = 3;
    localparam int PAUSE_PHASE   = 2;
    localparam int PEN_PHASE     = 5;

    typedef struct packed {
        logic [13:0] x;
        logic [13:0] y;
        logic [31:0] pixels;
        logic [5:0]  width;
        logic        last;
    } span_t;

    typedef struct {
        kind_t   kind;
        s_item_t item;
        bit      typed;
        span_t   span;
    } dir_row_t;

    typedef struct {
        int count;
        bit rnd_font;
        int height;
        int off_x;
        int off_y;
        int send_idle;
        int recv_idle;
        int items;
    } phase_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    // font model state
    logic [7:0]        glyph_code   [GLYPH_SLOTS];
    logic [5:0]        glyph_width  [GLYPH_SLOTS];
    logic [5:0]        glyph_height [GLYPH_SLOTS];
    logic signed [5:0] glyph_off_x  [GLYPH_SLOTS];
    logic signed [5:0] glyph_off_y  [GLYPH_SLOTS];
    logic [6:0]        glyph_adv    [GLYPH_SLOTS];
    bit                glyph_loaded [GLYPH_SLOTS];
    logic [31:0]       glyph_bits   [GLYPH_SLOTS][GLYPH_ROWS];
    bit                bits_loaded  [GLYPH_SLOTS][GLYPH_ROWS];
    int                pen_x  = 0;
    int                text_x = 0;
    int                text_y = 0;
    logic [8:0]        glyph_count = '0;
    logic [5:0]        font_height = '0;
    logic signed [5:0] font_off_x  = '0;
    logic signed [5:0] font_off_y  = '0;

    span_t pending_spans [$];
    span_t new_spans [$];
    dir_row_t dir_rows [$];

    int items_sent     = 0;
    int spans_checked  = 0;
    int font_settings  = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;

    bitmap_font_text_renderer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d spans outstanding", cycle_count,
                     pending_spans.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // span receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // span checker, m_tdata holds span_x, span_y, span_pixels, span_width from bit 0 up
    always @(posedge aclk) begin
        span_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_spans.size() == 0) begin
                $error("span with nothing expected: tdata %h last %b", m_tdata, m_tlast);
                error_count++;
            end else begin
                want = pending_spans.pop_front();
                if (m_tdata[13:0] !== want.x) begin
                    $error("span_x expected %h got %h", want.x, m_tdata[13:0]);
                    error_count++;
                end
                if (m_tdata[27:14] !== want.y) begin
                    $error("span_y expected %h got %h", want.y, m_tdata[27:14]);
                    error_count++;
                end
                if (m_tdata[59:28] !== want.pixels) begin
                    $error("span_pixels expected %h got %h", want.pixels, m_tdata[59:28]);
                    error_count++;
                end
                if (m_tdata[65:60] !== want.width) begin
                    $error("span_width expected %0d got %0d", want.width, m_tdata[65:60]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_row expected %b got %b", want.last, m_tlast);
                    error_count++;
                end
                spans_checked++;
            end
        end
    end

    function automatic int search_limit();
        return (glyph_count > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(glyph_count);
    endfunction

    // first searched slot holding the code, -1 on a miss
    function automatic int find_glyph(logic [7:0] code);
        for (int s = 0; s < search_limit(); s++)
            if (glyph_code[s] == code) return s;
        return -1;
    endfunction

    // updates the font model for one transaction and leaves its spans in new_spans
    function automatic void predict_spans(kind_t kind, s_item_t it);
        int          slot;
        int          bx;
        int          by;
        int          gh;
        int          adv;
        logic [31:0] mask;
        span_t       sp;
        new_spans.delete();
        slot = it.glyph_slot;
        case (kind)
            KIND_ORIGIN: begin
                text_x = $signed(it.origin_x);
                text_y = $signed(it.origin_y);
                pen_x  = 0;
            end
            KIND_METRICS: begin
                glyph_code[slot]   = it.char_code;
                glyph_width[slot]  = (it.glyph_width > 6'd32) ? 6'd32 : it.glyph_width;
                glyph_height[slot] = (it.glyph_height > 6'd32) ? 6'd32 : it.glyph_height;
                glyph_off_x[slot]  = it.glyph_offset_x;
                glyph_off_y[slot]  = it.glyph_offset_y;
                glyph_adv[slot]    = it.advance;
                glyph_loaded[slot] = 1'b1;
            end
            KIND_ROW: begin
                glyph_bits[slot][it.row_index]  = it.row_bits;
                bits_loaded[slot][it.row_index] = 1'b1;
            end
            KIND_DRAW: begin
                slot = find_glyph(it.char_code);
                if (slot >= 0) begin
                    mask = (glyph_width[slot] == 6'd0) ? 32'd0 :
                           32'hFFFF_FFFF << (32 - glyph_width[slot]);
                    gh   = glyph_height[slot];
                    adv  = glyph_adv[slot];
                    bx   = text_x + pen_x + int'(font_off_x) + int'(glyph_off_x[slot]);
                    by   = text_y + int'(font_height) - gh - int'(font_off_y)
                           - int'(glyph_off_y[slot]);
                    for (int r = 0; r < gh; r++) begin
                        sp.x      = 14'(bx);
                        sp.y      = 14'(by + r);
                        sp.pixels = glyph_bits[slot][r] & mask;
                        sp.width  = glyph_width[slot];
                        sp.last   = (r == gh - 1);
                        new_spans.push_back(sp);
                    end
                    pen_x = (pen_x + adv > PEN_MAX) ? PEN_MAX : pen_x + adv;
                end
            end
            default: ;
        endcase
    endfunction

    // offers one item, waits for the transaction, then records what it should produce
    task automatic send_item(kind_t kind, s_item_t it, bit typed = 1'b0, span_t typed_span = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        predict_spans(kind, it);
        if (typed) pending_spans.push_back(typed_span);
        else foreach (new_spans[i]) pending_spans.push_back(new_spans[i]);
        items_sent++;
    endtask

    // stops offering, waits for every expected span, then lets the block settle
    task automatic drain_spans(int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_spans.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // writes all four font registers back to back
    task automatic set_font(int count, int height, int off_x, int off_y);
        cfg_reg_t              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs[0] = CFG_GLYPH_COUNT;
        regs[1] = CFG_FONT_HEIGHT;
        regs[2] = CFG_FONT_OFFSET_X;
        regs[3] = CFG_FONT_OFFSET_Y;
        vals[0] = 9'(count);
        vals[1] = 9'(height & 'h3F);
        vals[2] = 9'(off_x & 'h3F);
        vals[3] = 9'(off_y & 'h3F);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (regs[i])
                CFG_GLYPH_COUNT:   glyph_count = vals[i];
                CFG_FONT_HEIGHT:   font_height = vals[i][5:0];
                CFG_FONT_OFFSET_X: font_off_x  = vals[i][5:0];
                CFG_FONT_OFFSET_Y: font_off_y  = vals[i][5:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
        font_settings++;
    endtask

    // every field but pad random, fields the kind does not use stay as noise
    function automatic s_item_t noise_item();
        logic [127:0] raw;
        s_item_t      it;
        raw    = {$urandom(), $urandom(), $urandom(), $urandom()};
        it     = raw[S_TDATA_W-1:0];
        it.pad = '0;
        return it;
    endfunction

    function automatic logic [7:0] pool_code();
        return ($urandom_range(9) < 6) ? 8'(8'h40 + $urandom_range(7)) : 8'($urandom_range(255));
    endfunction

    // short glyphs keep the bitmap loads down when a whole range of slots is filled
    task automatic load_metrics(int slot, logic [7:0] code, bit short_only = 1'b0);
        s_item_t it;
        int      pick;
        it             = noise_item();
        it.glyph_slot  = 8'(slot);
        it.char_code   = code;
        it.glyph_width = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                                  : 6'($urandom_range(32));
        pick = $urandom_range(19);
        if (short_only || pick < 13) it.glyph_height = 6'($urandom_range(4));
        else if (pick < 18) it.glyph_height = 6'($urandom_range(32, 5));
        else it.glyph_height = 6'($urandom_range(63, 33));
        send_item(KIND_METRICS, it);
    endtask

    task automatic load_row(int slot, int ridx);
        s_item_t it;
        it            = noise_item();
        it.glyph_slot = 8'(slot);
        it.row_index  = 5'(ridx);
        send_item(KIND_ROW, it);
    endtask

    // draws a code, first writing any bitmap row of the matching glyph still missing
    task automatic draw_char(logic [7:0] code);
        s_item_t it;
        int      slot;
        slot = find_glyph(code);
        if (slot >= 0)
            for (int r = 0; r < glyph_height[slot]; r++)
                if (!bits_loaded[slot][r]) load_row(slot, r);
        it           = noise_item();
        it.char_code = code;
        send_item(KIND_DRAW, it);
    endtask

    task automatic random_item(int limit);
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_item(KIND_ORIGIN, noise_item());
        end else if (pick < 23) begin
            if (limit > 0 && $urandom_range(9) < 7) load_metrics($urandom_range(limit - 1), pool_code());
            else load_metrics($urandom_range(255), pool_code());
        end else if (pick < 35) begin
            load_row($urandom_range(255), $urandom_range(31));
        end else if (limit > 0 && $urandom_range(3) != 0) begin
            draw_char(glyph_code[$urandom_range(limit - 1)]);
        end else begin
            draw_char(8'($urandom_range(255)));
        end
    endtask

    function automatic dir_row_t mk_row(kind_t kind, int code, int org_x, int org_y, int slot,
                                        int w, int h, int gox, int goy, int adv, int ridx,
                                        logic [31:0] bits);
        dir_row_t r;
        r.kind                = kind;
        r.item                = '0;
        r.item.char_code      = 8'(code);
        r.item.origin_x       = 12'(org_x);
        r.item.origin_y       = 12'(org_y);
        r.item.glyph_slot     = 8'(slot);
        r.item.glyph_width    = 6'(w);
        r.item.glyph_height   = 6'(h);
        r.item.glyph_offset_x = 6'(gox);
        r.item.glyph_offset_y = 6'(goy);
        r.item.advance        = 7'(adv);
        r.item.row_index      = 5'(ridx);
        r.item.row_bits       = bits;
        r.typed               = 1'b0;
        r.span                = '0;
        return r;
    endfunction

    initial begin
        dir_row_t row;
        phase_t   phases [6];
        s_item_t  it;
        int       limit;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GLYPH_COUNT;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_ORIGIN;
        m_tready  = 1'b0;

        // directed table, glyph search sees no slot until the font is set up
        dir_rows.push_back(mk_row(KIND_METRICS, 'h41, 0, 0, 0, 8, 1, 0, 0, 8, 0, '0));
        dir_rows.push_back(mk_row(KIND_ROW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        // zero glyph count: nothing matches
        dir_rows.push_back(mk_row(KIND_DRAW, 'h41, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        // from here the font searches four slots
        dir_rows.push_back(mk_row(KIND_METRICS, 'hFF, 0, 0, 1, 32, 1, 31, -32, 127, 0, '0));
        dir_rows.push_back(mk_row(KIND_ROW, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 32'h8000_0001));
        // zero width glyph of two rows
        dir_rows.push_back(mk_row(KIND_METRICS, 'h00, 0, 0, 2, 0, 2, -32, 31, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_ROW, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(KIND_ROW, 0, 0, 0, 2, 0, 0, 0, 0, 0, 1, 32'h0000_0000));
        // oversize width and zero height
        dir_rows.push_back(mk_row(KIND_METRICS, 'h43, 0, 0, 3, 63, 0, 5, -5, 127, 0, '0));
        // same code as slot 0 but outside the searched range
        dir_rows.push_back(mk_row(KIND_METRICS, 'h41, 0, 0, 255, 1, 63, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_ROW, 0, 0, 0, 255, 0, 0, 0, 0, 0, 31, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(KIND_ORIGIN, 0, -2048, 2047, 0, 0, 0, 0, 0, 0, 0, '0));
        row = mk_row(KIND_DRAW, 'h41, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
        row.typed = 1'b1;
        row.span  = '{x: 14'h3800, y: 14'h07FE, pixels: 32'hFF00_0000, width: 6'd8, last: 1'b1};
        dir_rows.push_back(row);
        row = mk_row(KIND_DRAW, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
        row.typed = 1'b1;
        row.span  = '{x: 14'h3827, y: 14'h081E, pixels: 32'h8000_0001, width: 6'd32, last: 1'b1};
        dir_rows.push_back(row);
        dir_rows.push_back(mk_row(KIND_DRAW, 'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_DRAW, 'h43, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        // no match
        dir_rows.push_back(mk_row(KIND_DRAW, 'h77, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_ORIGIN, 0, 2047, -2048, 0, 0, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_DRAW, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_DRAW, 'h41, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));

        // count, random font, height, off_x, off_y, sender idle, receiver idle, items
        phases[0] = '{12,  1'b1, 0,   0,   0,  15, 49, 16};
        phases[1] = '{0,   1'b0, 63, -32,  31, 15, 49, 6};
        phases[2] = '{7,   1'b0, 63, -32,  31, 49, 15, 14};
        phases[3] = '{20,  1'b0, 0,   31, -32, 49, 15, 14};
        phases[4] = '{256, 1'b1, 0,   0,   0,  0,  0,  12};
        phases[5] = '{511, 1'b0, 31,  0,   0,  0,  0,  8};

        send_idle_pct = 15;
        recv_idle_pct = 49;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (i == FONT_ROW) begin
                drain_spans(SETTLE_CYCLES);
                set_font(4, 0, 0, 0);
            end
            send_item(dir_rows[i].kind, dir_rows[i].item, dir_rows[i].typed, dir_rows[i].span);
        end

        foreach (phases[p]) begin
            drain_spans(SETTLE_CYCLES);
            send_idle_pct = phases[p].send_idle;
            recv_idle_pct = phases[p].recv_idle;
            if (phases[p].rnd_font)
                set_font(phases[p].count, $urandom_range(63), $urandom_range(63),
                         $urandom_range(63));
            else
                set_font(phases[p].count, phases[p].height, phases[p].off_x, phases[p].off_y);
            limit = search_limit();

            // every searched slot needs metrics before the first draw
            for (int s = 0; s < limit; s++)
                if (!glyph_loaded[s]) load_metrics(s, pool_code(), 1'b1);

            // pen saturation run under a long receiver hold-off
            if (p == PEN_PHASE) begin
                it                = noise_item();
                it.glyph_slot     = 8'd0;
                it.char_code      = 8'hE0;
                it.glyph_width    = 6'($urandom_range(32));
                it.glyph_height   = 6'd1;
                it.advance        = 7'd127;
                send_item(KIND_METRICS, it);
                send_item(KIND_ORIGIN, noise_item());
                hold_req = 1'b1;
                repeat (40) draw_char(8'hE0);
            end

            for (int n = 0; n < phases[p].items; n++) begin
                if (p == PAUSE_PHASE && n == phases[p].items / 2) drain_spans(0);
                random_item(limit);
            end
        end

        drain_spans(SETTLE_CYCLES);
        if (pending_spans.size() != 0) begin
            $error("%0d expected spans never arrived", pending_spans.size());
            error_count++;
        end

        $display("run covered %0d input items over %0d font settings, %0d row spans checked",
                 items_sent, font_settings, spans_checked);
        $display("including field extremes, search limits up to the full table and pen saturation");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
